/* rtl/htfd_pkg.sv */
// htfd_pkg: shared types, constants and the crc-8 byte function of the
// humidity/temperature frame decoder; no dependencies
package htfd_pkg;

   // byte position inside a three-byte frame
   localparam logic [1:0] POS_HIGH  = 2'd0;
   localparam logic [1:0] POS_LOW   = 2'd1;
   localparam logic [1:0] POS_CRC   = 2'd2;
   localparam logic [1:0] POS_SPARE = 2'd3;

   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [15:0] STATUS_MASK = 16'hFFFC;

   // fixed-point scale factors (x 2^-16) and offsets, hundredths
   localparam logic [14:0] TEMP_COEF   = 15'd17572;
   localparam logic [14:0] HUM_COEF    = 15'd12500;
   localparam logic signed [15:0] TEMP_OFFSET = 16'sd4685;
   localparam logic signed [15:0] HUM_OFFSET  = 16'sd600;

   // divide by 100 as multiply by ceil(2^19/100), exact below 43690
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   // frame data handed from the crc stage to the conversion stage
   typedef struct packed {
      logic [15:0] raw;
      logic [14:0] scaled;
      logic        crc_ok;
      logic        kind;
   } frame_type;

   // one byte of crc-8, msb first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

/* rtl/htfd_convert.sv */
// htfd_convert: offset removal and whole-unit truncation of a scaled reading
// uses htfd_pkg for offsets and the reciprocal of 100
module htfd_convert (
   input  logic [14:0]        scaled,
   input  logic               kind,
   output logic signed [14:0] value,
   output logic signed [8:0]  whole
);

   logic signed [15:0] val_wide;
   logic [13:0]        mag;
   logic [26:0]        quot_prod;
   logic [7:0]         quot;

   assign val_wide  = $signed({1'b0, scaled}) -
                      (kind ? htfd_pkg::HUM_OFFSET : htfd_pkg::TEMP_OFFSET);
   assign mag       = val_wide[15] ? 14'(-val_wide) : val_wide[13:0];
   assign quot_prod = mag * htfd_pkg::RECIP_100;
   assign quot      = quot_prod[26:htfd_pkg::RECIP_SHIFT];

   assign value = val_wide[14:0];
   assign whole = val_wide[15] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

endmodule

/* rtl/humidity_temp_frame_decoder_core.sv */
// humidity_temp_frame_decoder_core: top level of the sensor frame decoder
// uses htfd_pkg and htfd_convert
//
// throughput: one byte per cycle while rsp_tready stays high
// a held result and a full scaled-reading stage stall the checksum byte in the input register
// reset: synchronous, active high; clears frame position, crc and all valids
module humidity_temp_frame_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] rx_byte
   input  logic [1:0]  req_tuser,  // [0] is_humidity, [1] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [14:0] value_hundredths, [23:15] whole_value,
                                   // [39:24] raw_value
   output logic [1:0]  rsp_tuser   // [0] crc_ok, [1] kind_out
);

   // input register stage
   logic       a_valid_ff, a_valid_in;
   logic [7:0] a_byte_ff;
   logic       a_hum_ff;
   logic       a_start_ff;

   // frame state
   logic [1:0] byte_index_ff, byte_index_in;
   logic [7:0] crc_acc_ff, crc_acc_in;
   logic [7:0] high_data_ff, high_data_in;
   logic [7:0] low_data_ff, low_data_in;
   logic       frame_kind_ff, frame_kind_in;

   // scaled-reading stage
   logic                b_valid_ff, b_valid_in;
   htfd_pkg::frame_type b_frame_ff, b_frame_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [14:0] rsp_value_ff;
   logic signed [8:0]  rsp_whole_ff;
   logic [15:0]        rsp_raw_ff;
   logic               rsp_crc_ok_ff;
   logic               rsp_kind_ff;

   logic [1:0]  pos;
   logic        a_emits;
   logic        out_free;
   logic        b_free;
   logic        a_move;
   logic        req_take;
   logic [15:0] raw;
   logic [14:0] coef;
   logic [30:0] product;
   logic signed [14:0] conv_value;
   logic signed [8:0]  conv_whole;

   // a start flag forces the byte to be a new high byte
   assign pos     = a_start_ff ? htfd_pkg::POS_HIGH : byte_index_ff;
   assign a_emits = a_valid_ff && (pos == htfd_pkg::POS_CRC);

   // backpressure: only checksum bytes need room downstream
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign b_free     = !b_valid_ff || out_free;
   assign a_move     = a_valid_ff && (!a_emits || b_free);
   assign req_tready = !a_valid_ff || a_move;
   assign req_take   = req_tvalid && req_tready;

   // status bits cleared, then one multiply by the kind's scale factor
   assign raw     = {high_data_ff, low_data_ff} & htfd_pkg::STATUS_MASK;
   assign coef    = frame_kind_ff ? htfd_pkg::HUM_COEF : htfd_pkg::TEMP_COEF;
   assign product = coef * raw;

   always_comb begin
      byte_index_in = byte_index_ff;
      crc_acc_in    = crc_acc_ff;
      high_data_in  = high_data_ff;
      low_data_in   = low_data_ff;
      frame_kind_in = frame_kind_ff;
      b_frame_in    = b_frame_ff;
      a_valid_in    = req_take ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);
      b_valid_in    = out_free ? 1'b0 : b_valid_ff;
      rsp_valid_in  = out_free ? b_valid_ff : rsp_valid_ff;

      if (a_move) begin
         case (pos) inside
            htfd_pkg::POS_HIGH, htfd_pkg::POS_SPARE: begin
               high_data_in  = a_byte_ff;
               crc_acc_in    = htfd_pkg::crc8_byte(8'h00, a_byte_ff);
               frame_kind_in = a_hum_ff;
               byte_index_in = htfd_pkg::POS_LOW;
            end
            htfd_pkg::POS_LOW: begin
               low_data_in   = a_byte_ff;
               crc_acc_in    = htfd_pkg::crc8_byte(crc_acc_ff, a_byte_ff);
               byte_index_in = htfd_pkg::POS_CRC;
            end
            default: begin
               // checksum byte closes the frame
               byte_index_in     = htfd_pkg::POS_HIGH;
               b_valid_in        = 1'b1;
               b_frame_in.raw    = raw;
               b_frame_in.scaled = product[30:16];
               b_frame_in.crc_ok = (crc_acc_ff == a_byte_ff);
               b_frame_in.kind   = frame_kind_ff;
            end
         endcase
      end
   end

   htfd_convert u_convert (
      .scaled (b_frame_ff.scaled),
      .kind   (b_frame_ff.kind),
      .value  (conv_value),
      .whole  (conv_whole)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         byte_index_ff <= htfd_pkg::POS_HIGH;
         crc_acc_ff    <= 8'h00;
         high_data_ff  <= 8'h00;
         low_data_ff   <= 8'h00;
         frame_kind_ff <= 1'b0;
      end else begin
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         byte_index_ff <= byte_index_in;
         crc_acc_ff    <= crc_acc_in;
         high_data_ff  <= high_data_in;
         low_data_ff   <= low_data_in;
         frame_kind_ff <= frame_kind_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         a_byte_ff  <= req_tdata;
         a_hum_ff   <= req_tuser[0];
         a_start_ff <= req_tuser[1];
      end
      b_frame_ff <= b_frame_in;
      if (out_free && b_valid_ff) begin
         rsp_value_ff  <= conv_value;
         rsp_whole_ff  <= conv_whole;
         rsp_raw_ff    <= b_frame_ff.raw;
         rsp_crc_ok_ff <= b_frame_ff.crc_ok;
         rsp_kind_ff   <= b_frame_ff.kind;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_raw_ff, rsp_whole_ff, rsp_value_ff};
   assign rsp_tuser  = {rsp_kind_ff, rsp_crc_ok_ff};

`ifndef SYNTHESIS
   // the frame counter never reaches the spare code
   assert property (@(posedge clock) disable iff (reset)
      byte_index_ff != htfd_pkg::POS_SPARE)
      else $error("frame position reached spare code");

   // whole units agree with hundredths, truncated toward zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((32'(rsp_value_ff) - 32'(rsp_whole_ff) * 100) > -100 &&
                      (32'(rsp_value_ff) - 32'(rsp_whole_ff) * 100) < 100))
      else $error("whole value disagrees with hundredths");

   // status bits of a delivered raw reading are cleared
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_raw_ff[1:0] == 2'b00))
      else $error("status bits not cleared");

   // a new result only follows a completed frame in the conversion stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(b_valid_ff))
      else $error("result without completed frame");
`endif

endmodule

/* tb/frame_result_checker.sv */
`timescale 1ns / 1ps
// frame_result_checker: watches both streams of the sensor frame decoder, predicts each
// reading from the received bytes and compares it with what the block returns
// depends on htfd_pkg for the frame position codes
module frame_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fault_count,
   output int          pending_count
);

   localparam logic [7:0]  CRC8_POLY   = 8'h31;
   localparam logic [15:0] STATUS_BITS = 16'hFFFC;
   localparam int TEMP_SLOPE = 17572;
   localparam int TEMP_BASE  = -4685;
   localparam int RH_SLOPE   = 12500;
   localparam int RH_BASE    = -600;

   typedef struct {
      int hundredths;
      int whole;
      int raw;
      bit crc_ok;
      bit kind;
   } reading_type;

   reading_type expected_readings[$];

   logic [1:0] frame_pos;
   logic [7:0] crc_run;
   logic [7:0] first_byte;
   logic [7:0] second_byte;
   logic       frame_humid;
   int         faults = 0;
   int         pending_q = 0;

   assign fault_count   = faults;
   assign pending_count = pending_q;

   function automatic logic [7:0] sensor_crc8(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] acc;
      logic       msb;
      acc = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         msb = acc[7];
         acc = acc << 1;
         if (msb) acc = acc ^ CRC8_POLY;
      end
      return acc;
   endfunction

   // advance the frame state by one byte, queue a reading on the checksum byte
   task automatic decode_sensor_byte(input logic [7:0] b, input logic humid, input logic resync);
      logic [1:0]  pos;
      logic [15:0] raw;
      int          scaled;
      reading_type r;
      pos = resync ? htfd_pkg::POS_HIGH : frame_pos;
      case (pos)
         htfd_pkg::POS_HIGH, htfd_pkg::POS_SPARE: begin
            first_byte  = b;
            crc_run     = sensor_crc8(8'h00, b);
            frame_humid = humid;
            frame_pos   = htfd_pkg::POS_LOW;
         end
         htfd_pkg::POS_LOW: begin
            second_byte = b;
            crc_run     = sensor_crc8(crc_run, b);
            frame_pos   = htfd_pkg::POS_CRC;
         end
         default: begin
            frame_pos = htfd_pkg::POS_HIGH;
            raw       = {first_byte, second_byte} & STATUS_BITS;
            if (frame_humid) begin
               scaled       = (RH_SLOPE * int'(raw)) >> 16;
               r.hundredths = RH_BASE + scaled;
            end else begin
               scaled       = (TEMP_SLOPE * int'(raw)) >> 16;
               r.hundredths = TEMP_BASE + scaled;
            end
            r.whole  = r.hundredths / 100;
            r.raw    = int'(raw);
            r.crc_ok = (crc_run == b);
            r.kind   = frame_humid;
            expected_readings.push_back(r);
         end
      endcase
   endtask

   task automatic compare_field(input string label, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", label, want, got);
         faults++;
      end
   endtask

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         frame_pos   = htfd_pkg::POS_HIGH;
         crc_run     = 8'h00;
         first_byte  = 8'h00;
         second_byte = 8'h00;
         frame_humid = 1'b0;
         expected_readings.delete();
      end else begin
         if (req_tvalid && req_tready)
            decode_sensor_byte(req_tdata, req_tuser[0], req_tuser[1]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_readings.size() == 0) begin
               $error("reading returned with no completed frame waiting");
               faults++;
            end else begin
               want = expected_readings.pop_front();
               compare_field("value_hundredths", want.hundredths,
                             int'($signed(rsp_tdata[14:0])));
               compare_field("whole_value", want.whole, int'($signed(rsp_tdata[23:15])));
               compare_field("raw_value", want.raw, int'(rsp_tdata[39:24]));
               compare_field("crc_ok", int'(want.crc_ok), int'(rsp_tuser[0]));
               compare_field("kind_out", int'(want.kind), int'(rsp_tuser[1]));
            end
         end
      end
      pending_q <= expected_readings.size();
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench: drives sensor byte frames into humidity_temp_frame_decoder_core
// depends on htfd_pkg, the decoder rtl and frame_result_checker
module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;  // [7:0] rx_byte
   logic [1:0]  req_tuser = 2'b00;  // [0] is_humidity, [1] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // [14:0] value_hundredths, [23:15] whole_value,
                                    // [39:24] raw_value
   logic [1:0]  rsp_tuser;          // [0] crc_ok, [1] kind_out
   int          fault_count;
   int          pending_count;

   int          items_sent = 0;
   int          burst_left = 0;

   // 10 ns clock period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   humidity_temp_frame_decoder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   frame_result_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fault_count   (fault_count),
      .pending_count (pending_count)
   );

   // one byte transaction; the sender works in bursts with random gaps between them
   task automatic send_byte(input logic [7:0] b, input logic humid, input logic resync);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {resync, humid};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   // high byte, low byte, checksum; kind on the later bytes is noise the block must ignore
   task automatic send_frame(input logic [7:0] hi, input logic [7:0] lo, input logic humid,
                             input logic resync, input logic good_crc);
      logic [7:0] chk;
      chk = htfd_pkg::crc8_byte(htfd_pkg::crc8_byte(8'h00, hi), lo);
      if (!good_crc) chk = chk ^ 8'($urandom_range(1, 255));
      send_byte(hi, humid, resync);
      send_byte(lo, 1'($urandom_range(0, 1)), 1'b0);
      send_byte(chk, 1'($urandom_range(0, 1)), 1'b0);
   endtask

   // stop offering bytes until every completed frame has come back
   task automatic drain_readings();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // receiver: runs of always-ready, random and mostly-stalled cycles, plus two long
   // hold-offs so the pipeline fills up and pushes back on the byte stream
   initial begin
      int run_len;
      int mode;
      int cycle_no;
      run_len  = 0;
      mode     = 0;
      cycle_no = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (cycle_no == 600 || cycle_no == 1800) begin
            rsp_tready <= 1'b0;
            repeat (250) @(posedge clock);
            cycle_no += 250;
         end
         if (run_len == 0) begin
            mode    = $urandom_range(0, 2);
            run_len = $urandom_range(1, 40);
         end
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
         run_len--;
         cycle_no++;
         @(posedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      int  pick;
      bit  paused;
      paused = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes of the raw reading for both kinds; first frame needs no frame_start
      send_frame(8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
      send_frame(8'hFF, 8'hFF, 1'b0, 1'b1, 1'b1);
      send_frame(8'h00, 8'h00, 1'b1, 1'b1, 1'b1);
      send_frame(8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1);
      send_frame(8'h12, 8'h37, 1'b1, 1'b0, 1'b1);

      // resync on the low byte discards the partial frame; checksum deliberately wrong
      send_byte(8'hAB, 1'b0, 1'b1);
      send_byte(8'hCD, 1'b1, 1'b1);
      send_byte(8'hEF, 1'b0, 1'b0);
      send_byte(htfd_pkg::crc8_byte(htfd_pkg::crc8_byte(8'h00, 8'hCD), 8'hEF) ^ 8'h5A,
                1'b0, 1'b0);

      // resync on the checksum byte: no reading, that byte opens a new frame
      send_byte(8'h11, 1'b1, 1'b1);
      send_byte(8'h22, 1'b0, 1'b0);
      send_byte(8'h33, 1'b0, 1'b1);
      send_byte(8'h44, 1'b1, 1'b0);
      send_byte(htfd_pkg::crc8_byte(htfd_pkg::crc8_byte(8'h00, 8'h33), 8'h44), 1'b1, 1'b0);

      // kind flips after the first byte and must be ignored
      send_byte(8'h80, 1'b1, 1'b1);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(htfd_pkg::crc8_byte(htfd_pkg::crc8_byte(8'h00, 8'h80), 8'h00), 1'b0, 1'b0);

      // random part: mostly whole frames, some broken frames and stray bytes
      while (items_sent < 1350) begin
         if (!paused && items_sent >= 700) begin
            drain_readings();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       $urandom_range(0, 3) != 0);
         end else if (pick < 92) begin
            // truncated frame, the next byte restarts with frame_start
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            if ($urandom_range(0, 1))
               send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 1'b1, $urandom_range(0, 1) != 0);
         end else begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end
      end

      // let the last readings out, then keep the clock running to catch anything unexpected
      drain_readings();
      repeat (10) @(posedge clock);
      if (fault_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(5_000_000);
      $display("testbench NOT OK");
      $finish;
   end

endmodule
